>>> rtl/core/lps_pkg.sv
// Shared widths, constants and types for the linear prime sieve.
`timescale 1ns / 1ps
package lps_pkg;

  localparam int NUM_W  = 12;        // number, limit and stored prime width
  localparam int CUR_W  = 13;        // running number register
  localparam int CNT_W  = 11;        // prime count width
  localparam int PROD_W = 2 * NUM_W; // number times prime
  localparam int CNT_FIELD_MAX = 2047;
  localparam logic [CUR_W-1:0] FIRST_NUM = CUR_W'(2);

  typedef struct packed {
    logic done;  // one-cycle pulse, remainder ready
    logic zero;  // remainder is zero, valid with done
  } rem_stat_t;

endpackage

>>> rtl/core/lps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lps_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module lps_rem
  import lps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [NUM_W-1:0] divisor,
  output rem_stat_t        stat
);

  localparam int IW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [IW-1:0]    cnt_r;
  logic [NUM_W-1:0] dvd_r;
  logic [NUM_W-1:0] dsr_r;
  logic [NUM_W-1:0] rem_r;

  logic [NUM_W:0]   shifted;
  logic [NUM_W:0]   diff;
  logic [NUM_W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, dvd_r[NUM_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = (shifted >= {1'b0, dsr_r}) ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + IW'(1);
      if (cnt_r == IW'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

>>> rtl/core/linear_prime_sieve.sv
// Linear (Euler) prime sieve top level: sequencer over composite map and prime store.
//
//   channel  dir  payload                                    transfer when
//   in_      in   tdata[0] restart                           in_tvalid & in_tready
//   out_     out  tdata number/prime_count, tuser is_prime,  out_tvalid & out_tready
//                 tlast done_res
//   cfg_     in   cfg_data limit                             cfg_valid & cfg_ready
//
// One item at a time. An item reads the composite map, then walks the stored primes: each is
// read and multiplied by the number; a product within the limit is marked as the remainder
// unit runs, and the walk ends on a product above the limit, a zero remainder or last prime.
// Past-limit and restart items go straight to S_FIN. After reset and after each restart the
// composite map is cleared one entry a cycle, with in_tready low. Config writes are taken at
// any time. The result sits in an output register, so the next item is taken while it waits.
`timescale 1ns / 1ps
module linear_prime_sieve
  import lps_pkg::*;
#(
  parameter int LIMIT_MAX   = 4095,
  parameter int PRIME_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] restart
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [11:0] number, [22:12] prime_count, [23] zero
  output logic        out_tuser,   // [0] is_prime
  output logic        out_tlast,   // done_res
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data     // limit
);

  localparam int MAP_D = LIMIT_MAX + 1;
  localparam int MAW   = $clog2(MAP_D);
  localparam int SAW   = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
  localparam int LIM_CAP_I = (LIMIT_MAX < 4095) ? LIMIT_MAX : 4095;
  localparam int CNT_CAP_I = (PRIME_SLOTS < CNT_FIELD_MAX) ? PRIME_SLOTS : CNT_FIELD_MAX;
  localparam logic [NUM_W-1:0] LIM_CAP = NUM_W'(LIM_CAP_I);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);
  localparam logic [MAW-1:0]   CLR_LAST = MAW'(MAP_D - 1);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_W-1:0]  limit_r;
  logic [NUM_W-1:0]  eff_lim;
  logic [CUR_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [NUM_W-1:0]  n_r, n_nxt;
  logic [NUM_W-1:0]  p_r, p_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              prime_r, prime_nxt;
  logic [NUM_W-1:0]  res_num_r, res_num_nxt;
  logic              res_done_r, res_done_nxt;
  logic              clr_pend_r, clr_pend_nxt;
  logic [MAW-1:0]    clr_addr_r, clr_addr_nxt;
  logic              fin;

  logic              out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]  out_num_r, out_num_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_prime_r, out_prime_nxt;
  logic              out_done_r, out_done_nxt;

  logic              map_we;
  logic [MAW-1:0]    map_waddr;
  logic              map_wdata;
  logic              map_q;
  logic              st_we;
  logic [NUM_W-1:0]  st_q;
  logic              div_start;
  rem_stat_t         rem_stat;

  logic [CNT_W-1:0]  j_inc;

  assign eff_lim   = (limit_r > LIM_CAP) ? LIM_CAP : limit_r;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign j_inc     = j_r + CNT_W'(1);

  lps_ram #(.WIDTH(1), .DEPTH(MAP_D), .AW(MAW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (MAW'(cur_r)),
    .rdata (map_q)
  );

  lps_ram #(.WIDTH(NUM_W), .DEPTH(PRIME_SLOTS), .AW(SAW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (SAW'(cnt_r)),
    .wdata (n_r),
    .raddr (SAW'(j_r)),
    .rdata (st_q)
  );

  lps_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (p_r),
    .stat     (rem_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    prime_nxt     = prime_r;
    res_num_nxt   = res_num_r;
    res_done_nxt  = res_done_r;
    clr_pend_nxt  = clr_pend_r;
    clr_addr_nxt  = clr_addr_r;
    fin           = 1'b0;
    map_we        = 1'b0;
    map_waddr     = MAW'(prod_r);
    map_wdata     = 1'b1;
    st_we         = 1'b0;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_num_nxt   = out_num_r;
    out_cnt_nxt   = out_cnt_r;
    out_prime_nxt = out_prime_r;
    out_done_nxt  = out_done_r;

    unique case (state_r)
      S_CLR: begin
        map_we       = 1'b1;
        map_waddr    = clr_addr_r;
        map_wdata    = 1'b0;
        clr_addr_nxt = clr_addr_r + MAW'(1);
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata[0]) begin
            cnt_nxt      = '0;
            cur_nxt      = FIRST_NUM;
            res_num_nxt  = '0;
            prime_nxt    = 1'b0;
            res_done_nxt = (CUR_W'(eff_lim) < FIRST_NUM);
            clr_pend_nxt = 1'b1;
            clr_addr_nxt = '0;
            state_nxt    = S_FIN;
          end else if (cur_r > CUR_W'(eff_lim)) begin
            res_num_nxt  = '0;
            prime_nxt    = 1'b0;
            res_done_nxt = 1'b1;
            state_nxt    = S_FIN;
          end else begin
            n_nxt     = cur_r[NUM_W-1:0];
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        prime_nxt = !map_q;
        j_nxt     = '0;
        if (!map_q && cnt_r < CNT_CAP) begin
          st_we     = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_RD;
        end else if (cnt_r != '0) begin
          state_nxt = S_RD;
        end else begin
          fin = 1'b1;
        end
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        p_nxt     = st_q;
        prod_nxt  = PROD_W'(n_r) * PROD_W'(st_q);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (prod_r > PROD_W'(eff_lim)) begin
          fin = 1'b1;
        end else begin
          map_we    = 1'b1;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero || j_inc >= cnt_r) begin
            fin = 1'b1;
          end else begin
            j_nxt     = j_inc;
            state_nxt = S_RD;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_num_nxt   = res_num_r;
          out_cnt_nxt   = cnt_r;
          out_prime_nxt = prime_r;
          out_done_nxt  = res_done_r;
          clr_pend_nxt  = 1'b0;
          state_nxt     = clr_pend_r ? S_CLR : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      cur_nxt      = cur_r + CUR_W'(1);
      res_num_nxt  = n_r;
      res_done_nxt = (n_r == eff_lim);
      state_nxt    = S_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      limit_r     <= NUM_W'(4095);
      cur_r       <= FIRST_NUM;
      cnt_r       <= '0;
      j_r         <= '0;
      clr_pend_r  <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      j_r         <= j_nxt;
      clr_pend_r  <= clr_pend_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    p_r         <= p_nxt;
    prod_r      <= prod_nxt;
    prime_r     <= prime_nxt;
    res_num_r   <= res_num_nxt;
    res_done_r  <= res_done_nxt;
    out_num_r   <= out_num_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_prime_r <= out_prime_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_num_r};
  assign out_tuser  = out_prime_r;
  assign out_tlast  = out_done_r;

  // count never runs past the store capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_CAP)
    else $error("prime count above capacity");

  // the walk only reads store entries that were written
  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (j_r < cnt_r))
    else $error("prime store read beyond count");

  // a mark lands only inside the limit
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && map_we) |-> (prod_r <= PROD_W'(eff_lim)))
    else $error("composite mark above limit");

  // remainder completion always ends the wait
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && rem_stat.done) |=> (state_r != S_DIV))
    else $error("stuck waiting on remainder");

  // a result is only loaded into a free or draining output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_tready) |=> (state_r == S_FIN))
    else $error("result dropped while output stalled");

endmodule
